@@ sv/slab_pkg.sv @@
// Shared constants, types and command/status codes for the slab allocator.
// No dependencies; imported by every module of the block.
`default_nettype none
package slab_pkg;

  localparam int NUM_FRAMES      = 16;
  localparam int SLAB_BYTES_LOG2 = 12;
  localparam int MIN_CLASS_LOG2  = 5;
  localparam int MAX_CLASS_LOG2  = 11;

  localparam int NUM_CLASSES = MAX_CLASS_LOG2 - MIN_CLASS_LOG2 + 1;
  localparam int FRAME_W     = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int PTR_W       = $clog2(NUM_FRAMES + 1);
  localparam int SLOT_W      = SLAB_BYTES_LOG2 - MIN_CLASS_LOG2;
  localparam int FRESH_W     = SLOT_W + 1;
  localparam int CLS_W       = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int ORDER_W     = 5;
  localparam int ADDR_W      = 16;
  localparam int SIZE_W      = 16;
  localparam int GSIZE_W     = 12;
  localparam int LINK_AW     = FRAME_W + SLOT_W;

  typedef logic [FRAME_W-1:0] frame_t;
  typedef logic [PTR_W-1:0]   ptr_t;
  typedef logic [SLOT_W-1:0]  slot_t;
  typedef logic [FRESH_W-1:0] fresh_t;
  typedef logic [CLS_W-1:0]   cls_t;
  typedef logic [ORDER_W-1:0] order_t;

  localparam ptr_t NONE = PTR_W'(NUM_FRAMES);

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TOO_LARGE = 2'd1;
  localparam logic [1:0] ST_NO_FRAME  = 2'd2;
  localparam logic [1:0] ST_BAD_ADDR  = 2'd3;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [3:0] OP_NONE    = 4'd0;
  localparam logic [3:0] OP_LOAD    = 4'd1;
  localparam logic [3:0] OP_ERR     = 4'd2;
  localparam logic [3:0] OP_NEWSLAB = 4'd3;
  localparam logic [3:0] OP_USECUR  = 4'd4;
  localparam logic [3:0] OP_FRESH   = 4'd5;
  localparam logic [3:0] OP_RDLINK  = 4'd6;
  localparam logic [3:0] OP_LINK    = 4'd7;
  localparam logic [3:0] OP_EXHAUST = 4'd8;
  localparam logic [3:0] OP_PUSH    = 4'd9;
  localparam logic [3:0] OP_PICK    = 4'd10;
  localparam logic [3:0] OP_REMOVE  = 4'd11;
  localparam logic [3:0] OP_EMIT    = 4'd12;

  typedef struct packed {
    logic [3:0] op;
    logic [1:0] err;
  } dp_cmd_t;

  typedef struct packed {
    logic is_free;
    logic too_large;
    logic no_frame;
    logic has_cur;
    logic free_bad;
    logic head_nz;
    logic fresh_ok;
    logic cnt_last;
    logic release_frame;
    logic cur_is_f;
  } dp_stat_t;

  function automatic slot_t slots_in(cls_t c);
    return SLOT_W'((32'(1) << (SLOT_W - int'(c))) - 1);
  endfunction

endpackage
`default_nettype wire

@@ sv/slab_dp.sv @@
// Datapath: frame tables, class lists, slot-link memory and result registers.
// Depends on slab_pkg; driven by op codes from slab_ctrl.
`default_nettype none
module slab_dp import slab_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire dp_cmd_t             cmd,
  input  wire logic                in_cmd,
  input  wire logic [SIZE_W-1:0]   in_request_size,
  input  wire logic [ADDR_W-1:0]   in_address,
  output dp_stat_t                 stat,
  output logic      [ADDR_W-1:0]   out_slot_address,
  output logic      [1:0]          out_status,
  output logic      [GSIZE_W-1:0]  out_granted_size
);

  logic               is_free_r;
  order_t             order_r;
  logic               too_large_r;
  logic [ADDR_W-1:0]  addr_r;
  frame_t             f_r;

  logic   used_r    [NUM_FRAMES];
  cls_t   class_r   [NUM_FRAMES];
  slot_t  head_r    [NUM_FRAMES];
  slot_t  count_r   [NUM_FRAMES];
  fresh_t fresh_r   [NUM_FRAMES];
  ptr_t   after_r   [NUM_FRAMES];
  ptr_t   before_r  [NUM_FRAMES];
  ptr_t   current_r [NUM_CLASSES];
  ptr_t   first_r   [NUM_CLASSES];
  ptr_t   last_r    [NUM_CLASSES];

  slot_t  link_mem [NUM_FRAMES * (2**SLOT_W)];
  slot_t  rd_q;

  logic [ADDR_W-1:0]  res_slot_r;
  logic [1:0]         res_status_r;
  logic [GSIZE_W-1:0] res_size_r;

  order_t in_order;
  logic   in_too_large;
  cls_t   cls_w;
  frame_t ffree;
  logic   no_frame;
  slot_t  s_free;
  order_t ord_f;
  logic   free_bad;
  slot_t  s_take;
  ptr_t   x_ptr;
  frame_t x_idx;
  ptr_t   a_ptr;
  ptr_t   b_ptr;
  ptr_t   last_ptr;
  logic [LINK_AW-1:0] rd_addr;
  logic [ADDR_W-1:0]  take_addr;

  always_comb begin
    in_order = order_t'(16);
    for (int i = 16; i >= 0; i--) begin
      if ((17'(1) << i) >= {1'b0, in_request_size}) in_order = order_t'(i);
    end
    if (in_order < order_t'(MIN_CLASS_LOG2)) in_order = order_t'(MIN_CLASS_LOG2);
    in_too_large = (in_order > order_t'(MAX_CLASS_LOG2)) ||
                   (in_order >= order_t'(SLAB_BYTES_LOG2));
  end

  always_comb begin
    ffree = '0;
    no_frame = 1'b1;
    for (int i = NUM_FRAMES - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        ffree = frame_t'(i);
        no_frame = 1'b0;
      end
    end
  end

  assign cls_w = is_free_r ? class_r[f_r] : cls_t'(order_r - order_t'(MIN_CLASS_LOG2));

  always_comb begin
    ord_f  = order_t'(class_r[f_r]) + order_t'(MIN_CLASS_LOG2);
    s_free = SLOT_W'(32'(addr_r[SLAB_BYTES_LOG2-1:0]) >> ord_f);
    free_bad = ((32'(addr_r) >> SLAB_BYTES_LOG2) >= NUM_FRAMES) || !used_r[f_r] ||
               ((32'(addr_r[SLAB_BYTES_LOG2-1:0]) & ((32'(1) << ord_f) - 1)) != 0) ||
               (s_free == '0) || ({1'b0, s_free} >= fresh_r[f_r]);
  end

  assign stat.is_free       = is_free_r;
  assign stat.too_large     = too_large_r;
  assign stat.no_frame      = no_frame;
  assign stat.has_cur       = current_r[cls_w] < NONE;
  assign stat.free_bad      = free_bad;
  assign stat.head_nz       = head_r[f_r] != '0;
  assign stat.fresh_ok      = fresh_r[f_r] <= {1'b0, slots_in(cls_w)};
  assign stat.cnt_last      = count_r[f_r] == slot_t'(1);
  assign stat.release_frame = ({1'b0, count_r[f_r]} + FRESH_W'(1)) >= {1'b0, slots_in(cls_w)};
  assign stat.cur_is_f      = current_r[cls_w] == {1'b0, f_r};

  assign x_ptr    = (cmd.op == OP_PICK) ? first_r[cls_w] : {1'b0, f_r};
  assign x_idx    = x_ptr[FRAME_W-1:0];
  assign a_ptr    = after_r[x_idx];
  assign b_ptr    = before_r[x_idx];
  assign last_ptr = last_r[cls_w];
  assign rd_addr  = {f_r, head_r[f_r]};
  assign s_take   = (cmd.op == OP_FRESH) ? fresh_r[f_r][SLOT_W-1:0] : head_r[f_r];
  assign take_addr = ADDR_W'((32'(f_r) << SLAB_BYTES_LOG2) | (32'(s_take) << order_r));

  always_ff @(posedge clk) begin
    rd_q <= link_mem[rd_addr];
    if (cmd.op == OP_PUSH) link_mem[{f_r, s_free}] <= head_r[f_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_FRAMES; i++) used_r[i] <= 1'b0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        current_r[i] <= NONE;
        first_r[i]   <= NONE;
        last_r[i]    <= NONE;
      end
    end else begin
      unique case (cmd.op)
        OP_NEWSLAB: begin
          used_r[ffree]     <= 1'b1;
          current_r[cls_w]  <= {1'b0, ffree};
        end
        OP_PUSH: begin
          if (count_r[f_r] == '0) begin
            if (last_ptr >= NONE) first_r[cls_w] <= {1'b0, f_r};
            last_r[cls_w] <= {1'b0, f_r};
          end
          if (stat.release_frame) used_r[f_r] <= 1'b0;
        end
        OP_PICK, OP_REMOVE: begin
          if (x_ptr < NONE) begin
            if (b_ptr >= NONE) first_r[cls_w] <= a_ptr;
            if (a_ptr >= NONE) last_r[cls_w] <= b_ptr;
          end
          if (cmd.op == OP_PICK) current_r[cls_w] <= x_ptr;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        is_free_r    <= in_cmd == CMD_FREE;
        order_r      <= in_order;
        too_large_r  <= in_too_large;
        addr_r       <= in_address;
        f_r          <= frame_t'(32'(in_address) >> SLAB_BYTES_LOG2);
        res_slot_r   <= '0;
        res_status_r <= ST_OK;
        res_size_r   <= '0;
      end
      OP_ERR: res_status_r <= cmd.err;
      OP_NEWSLAB: begin
        f_r            <= ffree;
        class_r[ffree] <= cls_w;
        head_r[ffree]  <= '0;
        count_r[ffree] <= slots_in(cls_w);
        fresh_r[ffree] <= fresh_t'(1);
      end
      OP_USECUR: f_r <= current_r[cls_w][FRAME_W-1:0];
      OP_FRESH, OP_LINK: begin
        if (cmd.op == OP_FRESH) fresh_r[f_r] <= fresh_r[f_r] + fresh_t'(1);
        else head_r[f_r] <= rd_q;
        count_r[f_r] <= count_r[f_r] - slot_t'(1);
        res_slot_r   <= take_addr;
        res_size_r   <= GSIZE_W'(32'(1) << order_r);
      end
      OP_EXHAUST: begin
        count_r[f_r] <= '0;
        res_status_r <= ST_NO_FRAME;
      end
      OP_PUSH: begin
        head_r[f_r]  <= s_free;
        count_r[f_r] <= count_r[f_r] + slot_t'(1);
        if (count_r[f_r] == '0) begin
          after_r[f_r]  <= NONE;
          before_r[f_r] <= last_ptr;
          if (last_ptr < NONE) after_r[last_ptr[FRAME_W-1:0]] <= {1'b0, f_r};
        end
      end
      OP_PICK, OP_REMOVE: begin
        if (x_ptr < NONE) begin
          if (b_ptr < NONE) after_r[b_ptr[FRAME_W-1:0]] <= a_ptr;
          if (a_ptr < NONE) before_r[a_ptr[FRAME_W-1:0]] <= b_ptr;
        end
      end
      OP_EMIT: begin
        out_slot_address <= res_slot_r;
        out_status       <= res_status_r;
        out_granted_size <= res_size_r;
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

@@ sv/slab_ctrl.sv @@
// Controller: sequences decode, slot take, push and list fix-up for one request.
// Depends on slab_pkg; commands slab_dp and owns both handshakes.
`default_nettype none
module slab_ctrl import slab_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_ALOC = 3'd2;
  localparam logic [2:0] S_RDW  = 3'd3;
  localparam logic [2:0] S_FIX  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.op        = OP_NONE;
    cmd.err       = ST_OK;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (stat.is_free) begin
          if (stat.free_bad) begin
            cmd.op    = OP_ERR;
            cmd.err   = ST_BAD_ADDR;
            state_nxt = S_DONE;
          end else begin
            cmd.op    = OP_PUSH;
            state_nxt = stat.release_frame ? S_FIX : S_DONE;
          end
        end else if (stat.too_large) begin
          cmd.op    = OP_ERR;
          cmd.err   = ST_TOO_LARGE;
          state_nxt = S_DONE;
        end else if (stat.has_cur) begin
          cmd.op    = OP_USECUR;
          state_nxt = S_ALOC;
        end else if (stat.no_frame) begin
          cmd.op    = OP_ERR;
          cmd.err   = ST_NO_FRAME;
          state_nxt = S_DONE;
        end else begin
          cmd.op    = OP_NEWSLAB;
          state_nxt = S_ALOC;
        end
      end
      S_ALOC: begin
        if (stat.head_nz) begin
          cmd.op    = OP_RDLINK;
          state_nxt = S_RDW;
        end else if (stat.fresh_ok) begin
          cmd.op    = OP_FRESH;
          state_nxt = stat.cnt_last ? S_FIX : S_DONE;
        end else begin
          cmd.op    = OP_EXHAUST;
          state_nxt = S_FIX;
        end
      end
      S_RDW: begin
        cmd.op    = OP_LINK;
        state_nxt = stat.cnt_last ? S_FIX : S_DONE;
      end
      S_FIX: begin
        cmd.op    = (stat.is_free && !stat.cur_is_f) ? OP_REMOVE : OP_PICK;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.op        = OP_EMIT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

@@ sv/slab_size_class_allocator.sv @@
// Slab allocator with power-of-two size classes over a fixed pool of frames.
// Requests enter on the in_ channel (cmd 0 allocate request_size bytes,
// cmd 1 free address); one result beat per request leaves on out_.
// An allocate returns the slot address and class size, or a status code;
// a free returns status only.
// One request is in flight at a time. Bad or oversized requests go from
// decode straight to the result; an allocate takes a slot from the fresh
// region or through the slot-link memory, and a free pushes its slot; an
// allocate that fills its slab, and a free that returns its frame to the
// pool, then take a partial-list fix-up step.
// The slot-link memory has a registered read port, which adds a wait step
// to a linked allocate.
// The result sits in an output register, so the next request is accepted
// while the previous result waits; a stalled receiver holds the block in
// its final step until the output register frees up.
// Reset (rst_n low, synchronous) empties the frame pool and all class lists.
// Depends on slab_pkg, slab_ctrl and slab_dp.
`default_nettype none
module slab_size_class_allocator import slab_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                in_cmd,
  input  wire logic [SIZE_W-1:0]   in_request_size,
  input  wire logic [ADDR_W-1:0]   in_address,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic      [ADDR_W-1:0]   out_slot_address,
  output logic      [1:0]          out_status,
  output logic      [GSIZE_W-1:0]  out_granted_size
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  slab_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  slab_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_cmd           (in_cmd),
    .in_request_size  (in_request_size),
    .in_address       (in_address),
    .stat             (stat),
    .out_slot_address (out_slot_address),
    .out_status       (out_status),
    .out_granted_size (out_granted_size)
  );

endmodule
`default_nettype wire

@@ sv/slab_checker.sv @@
// Port-level checks on the allocator's result channel, bound to the top level.
// Depends on slab_pkg.
`default_nettype none
module slab_checker import slab_pkg::*; (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [ADDR_W-1:0]  out_slot_address,
  input wire logic [1:0]         out_status,
  input wire logic [GSIZE_W-1:0] out_granted_size
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_slot_address) &&
      $stable(out_status) && $stable(out_granted_size))
    else $error("result beat changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_slot_address == '0 && out_granted_size == '0)
    else $error("error beat carries a slot or size");

  a_pow2: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_granted_size != '0 |-> $onehot(out_granted_size) && out_status == ST_OK)
    else $error("granted size is not a power of two");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind slab_size_class_allocator slab_checker u_slab_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_slot_address (out_slot_address),
  .out_status       (out_status),
  .out_granted_size (out_granted_size)
);
`default_nettype wire
